/* src/gsm_pkg.sv */
// Shared constants, codes and types of the golden-section minimizer.
package gsm_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STOP_W    = 31;

  // 0.618 in the fixed-point format, rounded to nearest
  localparam logic [FRAC_BITS-1:0] GOLDEN_Q =
    FRAC_BITS'(((64'd618 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [FRAC_BITS-1:0] HALF_LSB = FRAC_BITS'(64'd1 << (FRAC_BITS - 1));

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_VALUE = 1'b1;

  localparam logic [1:0] KIND_EVAL   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_IGNORE = 2'd2;

  localparam logic CFG_STOP_WIDTH = 1'b0;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_FIRST = 4'b0010,
    PH_PROBE = 4'b0100,
    PH_MID   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] point;
    logic signed [VAL_W-1:0] min_value;
  } result_t;

endpackage

/* src/golden_section_minimizer.sv */
// Top level of the golden-section minimization sequencer.
// A start request (tuser = 0) carries the bounds low and high in Q16.16; the block answers
// with an evaluate result (kind 0) naming the first inner probe. Each value request
// (tuser = 1) returns the function value at the last named point and is answered by the
// next point to evaluate; the interval shrinks by 0.618 per compare, ties keeping the right
// part. Once the width is at or below stop_width (APB register at byte address 0, reset 1),
// the block asks for the midpoint and answers that value with a done result (kind 1) giving
// the position and value. A value while idle or a start while busy yields an ignored
// result (kind 2) and leaves the search as it was. Every request gives exactly one result,
// registered in the cycle after it is taken; the block takes a request in every cycle while the result
// register is empty or being drained, so it follows an evaluator at one request per clock.
// The cycle holds one 33x16 multiply for the golden step, shared by the start and compare
// paths, followed by the probe add.
module golden_section_minimizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // [31:0] start_low, [63:32] start_high, [95:64] func_value
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] point, [63:32] min_value
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned W = gsm_pkg::VAL_W;

  // search state
  gsm_pkg::phase_e         phase_q, phase_d;
  logic signed [W-1:0]     ilo_q, ilo_d, ihi_q, ihi_d;
  logic signed [W-1:0]     plo_q, plo_d, phi_q, phi_d;
  logic signed [W-1:0]     kept_q, kept_d;
  logic                    afl_q, afl_d;
  logic [gsm_pkg::STOP_W-1:0] stop_q;

  // result register
  logic                    out_valid_q;
  gsm_pkg::result_t        res_q, res_d;

  logic                    req_acc;
  logic                    is_value;
  logic signed [W-1:0]     in_lo, in_hi, in_val;

  // compare path
  logic signed [W-1:0]     left_val, right_val;
  logic                    take_left;
  logic signed [W-1:0]     new_lo, new_hi, new_kept;
  logic signed [32:0]      w_start, w_adv, w_sel;
  logic                    keep_going;
  logic signed [32:0]      mid_sum;
  logic signed [32:0]      step;
  logic signed [33:0]      start_plo, start_phi, adv_phi, adv_plo;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == gsm_pkg::CFG_STOP_WIDTH) ? {1'b0, stop_q} : 32'd0;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign req_acc       = s_axis_tvalid && s_axis_tready;

  assign is_value = (s_axis_tuser[0] == gsm_pkg::REQ_VALUE);
  assign in_lo    = $signed(s_axis_tdata[31:0]);
  assign in_hi    = $signed(s_axis_tdata[63:32]);
  assign in_val   = $signed(s_axis_tdata[95:64]);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {res_q.min_value, res_q.point};

  // Order the two probe values: the kept one sits on the side it came from.
  always_comb begin
    left_val  = afl_q ? kept_q : in_val;
    right_val = afl_q ? in_val : kept_q;
    take_left = left_val < right_val;
    new_lo    = take_left ? ilo_q : plo_q;
    new_hi    = take_left ? phi_q : ihi_q;
    new_kept  = take_left ? left_val : right_val;
    w_start   = 33'(in_hi) - 33'(in_lo);
    w_adv     = 33'(new_hi) - 33'(new_lo);
    keep_going = w_adv > $signed({2'b00, stop_q});
    mid_sum   = 33'(new_lo) + 33'(new_hi);
    w_sel     = is_value ? w_adv : w_start;
  end

  gsm_golden_step u_step (
    .width_i (w_sel),
    .step_o  (step)
  );

  always_comb begin
    start_plo = 34'(in_hi) - 34'(step);
    start_phi = 34'(in_lo) + 34'(step);
    adv_phi   = 34'(new_lo) + 34'(step);
    adv_plo   = 34'(new_hi) - 34'(step);
  end

  // Next search state and the result for the request at the input.
  always_comb begin
    phase_d = phase_q;
    ilo_d   = ilo_q;
    ihi_d   = ihi_q;
    plo_d   = plo_q;
    phi_d   = phi_q;
    kept_d  = kept_q;
    afl_d   = afl_q;
    res_d.kind      = gsm_pkg::KIND_IGNORE;
    res_d.point     = '0;
    res_d.min_value = '0;

    if (!is_value) begin
      if (phase_q == gsm_pkg::PH_IDLE) begin
        ilo_d   = in_lo;
        ihi_d   = in_hi;
        plo_d   = start_plo[W-1:0];
        phi_d   = start_phi[W-1:0];
        phase_d = gsm_pkg::PH_FIRST;
        res_d.kind  = gsm_pkg::KIND_EVAL;
        res_d.point = start_plo[W-1:0];
      end
    end else begin
      unique case (phase_q)
        gsm_pkg::PH_IDLE: begin
          // drop a value with no search running
        end
        gsm_pkg::PH_FIRST: begin
          kept_d  = in_val;
          afl_d   = 1'b1;
          phase_d = gsm_pkg::PH_PROBE;
          res_d.kind  = gsm_pkg::KIND_EVAL;
          res_d.point = phi_q;
        end
        gsm_pkg::PH_PROBE: begin
          ilo_d  = new_lo;
          ihi_d  = new_hi;
          kept_d = new_kept;
          afl_d  = !take_left;
          res_d.kind = gsm_pkg::KIND_EVAL;
          if (keep_going) begin
            phase_d = gsm_pkg::PH_PROBE;
            if (!take_left) begin
              // advance from the left: old right probe becomes the left one
              plo_d       = phi_q;
              phi_d       = adv_phi[W-1:0];
              res_d.point = adv_phi[W-1:0];
            end else begin
              phi_d       = plo_q;
              plo_d       = adv_plo[W-1:0];
              res_d.point = adv_plo[W-1:0];
            end
          end else begin
            // narrow enough: ask for the midpoint, rounded toward minus infinity
            plo_d       = mid_sum[W:1];
            phase_d     = gsm_pkg::PH_MID;
            res_d.point = mid_sum[W:1];
          end
        end
        gsm_pkg::PH_MID: begin
          phase_d         = gsm_pkg::PH_IDLE;
          res_d.kind      = gsm_pkg::KIND_DONE;
          res_d.point     = plo_q;
          res_d.min_value = in_val;
        end
        default: begin
          phase_d = gsm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gsm_pkg::PH_IDLE;
      ilo_q   <= '0;
      ihi_q   <= '0;
      plo_q   <= '0;
      phi_q   <= '0;
      kept_q  <= '0;
      afl_q   <= 1'b0;
    end else if (req_acc) begin
      phase_q <= phase_d;
      ilo_q   <= ilo_d;
      ihi_q   <= ihi_d;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      kept_q  <= kept_d;
      afl_q   <= afl_d;
    end
  end

  // Hold the result until taken; load a new one whenever a request is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= gsm_pkg::STOP_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == gsm_pkg::CFG_STOP_WIDTH) begin
      stop_q <= pwdata[gsm_pkg::STOP_W-1:0];
    end
  end

endmodule

/* src/gsm_golden_step.sv */
// Golden-ratio step: sign(w) * round(|w| * 0.618), ties away from zero.
module gsm_golden_step (
  input  logic signed [32:0] width_i,
  output logic signed [32:0] step_o
);

  localparam int unsigned PROD_W = 33 + gsm_pkg::FRAC_BITS;

  logic              neg;
  logic [32:0]       mag;
  logic [PROD_W-1:0] prod;
  logic [32:0]       rnd;

  always_comb begin
    neg  = width_i[32];
    mag  = neg ? 33'(-width_i) : 33'(width_i);
    prod = PROD_W'(mag) * PROD_W'(gsm_pkg::GOLDEN_Q) + PROD_W'(gsm_pkg::HALF_LSB);
    rnd  = prod[gsm_pkg::FRAC_BITS +: 33];
    step_o = neg ? -$signed(rnd) : $signed(rnd);
  end

endmodule

/* src/gsm_checker.sv */
// Port-level checks of the golden-section minimizer, bound to the top level.
module gsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // every request shows a result in the next cycle
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("request produced no result");

  // requests are refused only while a result is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request refused without backpressure");

  // only a done result carries a value
  a_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != gsm_pkg::KIND_DONE |-> m_axis_tdata[63:32] == 32'd0)
    else $error("value on a non-done result");

  // ignored results carry no point, and no fourth kind exists
  a_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == gsm_pkg::KIND_EVAL || m_axis_tuser == gsm_pkg::KIND_DONE
                       || (m_axis_tuser == gsm_pkg::KIND_IGNORE && m_axis_tdata[31:0] == 32'd0)))
    else $error("bad result kind or point");

endmodule

bind golden_section_minimizer gsm_checker u_gsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/golden_section_minimizer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the golden-section minimizer on its result stream.
module golden_section_minimizer_tb;

  // Six random phases of PHASE_ITEMS useful requests each, about 750 in all. The budget
  // covers every request waiting out the longest sender gap and the longest receiver
  // stall, plus the register writes between phases.
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASE_ITEMS = 125;

  typedef struct {
    logic                             rtype;
    logic signed [gsm_pkg::VAL_W-1:0] lo;
    logic signed [gsm_pkg::VAL_W-1:0] hi;
    logic signed [gsm_pkg::VAL_W-1:0] fv;
  } gsm_req_t;

  // How the fake evaluator answers a point: distance to an aim, its negative,
  // one constant (every compare ties), a few levels (frequent ties) or noise.
  typedef enum int {SH_BOWL, SH_HILL, SH_FLAT, SH_STEPS, SH_NOISE} shape_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;   // [31:0] start_low, [63:32] start_high, [95:64] func_value
  logic [0:0]  s_axis_tuser  = '0;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [31:0] point, [63:32] min_value
  logic [1:0]  m_axis_tuser;         // [1:0] result_kind
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  golden_section_minimizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting for the driver, and the results they are predicted to give,
  // both in acceptance order.
  gsm_req_t         requests_todo[$];
  gsm_pkg::result_t answers_due[$];

  // Shadow of the search state, advanced once per request in queue order.
  logic [gsm_pkg::STOP_W-1:0]       stop_w;
  gsm_pkg::phase_e                  search_ph;
  longint                           win_lo, win_hi, inner_lo, inner_hi, reuse_val;
  bit                               move_lo;
  logic signed [gsm_pkg::VAL_W-1:0] last_point;

  int fault_count  = 0;
  int useful_items = 0;
  int cycle_count  = 0;
  int req_gap      = 0;
  int rsp_stall    = 0;
  bit drv_calm     = 1'b0;
  bit rsp_calm     = 1'b0;
  gsm_pkg::result_t seen_answer, due_answer;

  function automatic void flag_fault(string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endfunction

  // Mostly short gaps, a few long ones; none at all while calm.
  function automatic int gap_len(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 0.618 of a width, rounded to nearest with ties away from zero.
  function automatic longint golden_step(longint w);
    longint unsigned mag, r;
    mag = (w < 0) ? -w : w;
    r = (mag * gsm_pkg::GOLDEN_Q + gsm_pkg::HALF_LSB) >> gsm_pkg::FRAC_BITS;
    return (w < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Keep the side with the smaller value (ties keep the right part), then name
  // the next probe or, once narrow enough, the midpoint.
  function automatic gsm_pkg::result_t narrow(longint left_v, longint right_v);
    gsm_pkg::result_t r;
    longint           w, st;
    r      = '0;
    r.kind = gsm_pkg::KIND_EVAL;
    if (left_v < right_v) begin
      win_hi    = inner_hi;
      reuse_val = left_v;
      move_lo   = 1'b0;
    end else begin
      win_lo    = inner_lo;
      reuse_val = right_v;
      move_lo   = 1'b1;
    end
    w = win_hi - win_lo;
    if (w > longint'(stop_w)) begin
      st = golden_step(w);
      if (move_lo) begin
        inner_lo = inner_hi;
        inner_hi = win_lo + st;
        r.point  = inner_hi[31:0];
      end else begin
        inner_hi = inner_lo;
        inner_lo = win_hi - st;
        r.point  = inner_lo[31:0];
      end
      search_ph = gsm_pkg::PH_PROBE;
    end else begin
      inner_lo  = (win_lo + win_hi) >>> 1;
      r.point   = inner_lo[31:0];
      search_ph = gsm_pkg::PH_MID;
    end
    return r;
  endfunction

  function automatic gsm_pkg::result_t minimizer_answer(
      input logic rtype, input logic signed [gsm_pkg::VAL_W-1:0] lo, hi, fv);
    gsm_pkg::result_t r;
    longint           st;
    r      = '0;
    r.kind = gsm_pkg::KIND_IGNORE;
    if (rtype == gsm_pkg::REQ_START) begin
      // A start during a search leaves the search alone.
      if (search_ph != gsm_pkg::PH_IDLE) return r;
      win_lo    = lo;
      win_hi    = hi;
      st        = golden_step(win_hi - win_lo);
      inner_lo  = win_hi - st;
      inner_hi  = win_lo + st;
      search_ph = gsm_pkg::PH_FIRST;
      r.kind    = gsm_pkg::KIND_EVAL;
      r.point   = inner_lo[31:0];
      return r;
    end
    case (search_ph)
      gsm_pkg::PH_FIRST: begin
        reuse_val = fv;
        move_lo   = 1'b1;
        search_ph = gsm_pkg::PH_PROBE;
        r.kind    = gsm_pkg::KIND_EVAL;
        r.point   = inner_hi[31:0];
      end
      gsm_pkg::PH_PROBE: r = move_lo ? narrow(reuse_val, fv) : narrow(fv, reuse_val);
      gsm_pkg::PH_MID: begin
        search_ph   = gsm_pkg::PH_IDLE;
        r.kind      = gsm_pkg::KIND_DONE;
        r.point     = inner_lo[31:0];
        r.min_value = fv;
      end
      default: ;  // value while idle stays ignored
    endcase
    return r;
  endfunction

  // Queue one request together with its predicted result.
  function automatic void issue(input logic rtype,
                                input logic signed [gsm_pkg::VAL_W-1:0] lo, hi, fv);
    gsm_req_t         q;
    gsm_pkg::result_t a;
    q.rtype = rtype;
    q.lo    = lo;
    q.hi    = hi;
    q.fv    = fv;
    a = minimizer_answer(rtype, lo, hi, fv);
    if (a.kind == gsm_pkg::KIND_EVAL) last_point = a.point;
    if (a.kind != gsm_pkg::KIND_IGNORE) useful_items++;
    requests_todo.push_back(q);
    answers_due.push_back(a);
  endfunction

  function automatic logic signed [gsm_pkg::VAL_W-1:0] value_at(
      shape_e shape, logic signed [gsm_pkg::VAL_W-1:0] pt, aim);
    longint d;
    d = longint'(pt) - longint'(aim);
    if (d < 0) d = -d;
    d = d >>> 1;  // keep the distance inside 31 bits
    case (shape)
      SH_BOWL:  return d[31:0];
      SH_HILL:  return -d[31:0];
      SH_FLAT:  return aim;
      SH_STEPS: return $urandom_range(0, 3);
      default:  return $urandom;
    endcase
  endfunction

  // Drive one full search: a start, then a value for every point the block asks for.
  // Noisy searches also carry starts while busy and stray values once idle.
  task automatic run_search(input logic signed [gsm_pkg::VAL_W-1:0] lo, hi,
                            input shape_e shape,
                            input logic signed [gsm_pkg::VAL_W-1:0] aim, input bit noisy);
    int steps;
    steps = 0;
    issue(gsm_pkg::REQ_START, lo, hi, $urandom);
    while (search_ph != gsm_pkg::PH_IDLE && steps < 1000) begin
      if (noisy && $urandom_range(0, 19) == 0)
        issue(gsm_pkg::REQ_START, $urandom, $urandom, $urandom);
      issue(gsm_pkg::REQ_VALUE, $urandom, $urandom, value_at(shape, last_point, aim));
      steps++;
    end
    if (noisy && $urandom_range(0, 3) == 0)
      issue(gsm_pkg::REQ_VALUE, $urandom, $urandom, $urandom);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Let every outstanding request and result drain, then rewrite stop_width and read it back.
  task automatic configure_stop(input logic [gsm_pkg::STOP_W-1:0] w);
    logic [31:0] rd;
    while (requests_todo.size() != 0 || answers_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    apb_access(1'b1, {gsm_pkg::CFG_STOP_WIDTH, 2'b00}, {1'b0, w}, rd);
    apb_access(1'b0, {gsm_pkg::CFG_STOP_WIDTH, 2'b00}, '0, rd);
    if (rd !== {1'b0, w})
      flag_fault($sformatf("mismatch: stop_width readback exp %0d got %0d", w, rd));
    stop_w = w;
  endtask

  // Request driver: present the head of the queue, hold it until taken, then pop it
  // and pick the gap before the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      req_gap = 0;
    end else begin
      if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
      if (s_axis_tvalid && s_axis_tready) begin
        void'(requests_todo.pop_front());
        req_gap = gap_len(drv_calm);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_gap > 0) begin
          req_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (requests_todo.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {requests_todo[0].fv, requests_todo[0].hi, requests_todo[0].lo};
          s_axis_tuser  <= requests_todo[0].rtype;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random, compare each taken result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
      if (m_axis_tvalid && m_axis_tready) begin
        seen_answer.kind      = m_axis_tuser;
        seen_answer.point     = m_axis_tdata[31:0];
        seen_answer.min_value = m_axis_tdata[63:32];
        if (answers_due.size() == 0) begin
          flag_fault($sformatf("mismatch: unexpected result kind %0d point %0d value %0d",
                               seen_answer.kind, seen_answer.point, seen_answer.min_value));
        end else begin
          due_answer = answers_due.pop_front();
          if (seen_answer.kind !== due_answer.kind || seen_answer.point !== due_answer.point ||
              seen_answer.min_value !== due_answer.min_value)
            flag_fault($sformatf({"mismatch: exp kind %0d point %0d value %0d, ",
                                  "got kind %0d point %0d value %0d"},
                                 due_answer.kind, due_answer.point, due_answer.min_value,
                                 seen_answer.kind, seen_answer.point, seen_answer.min_value));
        end
        rsp_stall = gap_len(rsp_calm);
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hard stop for a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic signed [gsm_pkg::VAL_W-1:0] lo, hi, aim;
    int                               roll;
    logic [gsm_pkg::STOP_W-1:0]       next_stop;
    int                               goal;

    stop_w     = 1;
    search_ph  = gsm_pkg::PH_IDLE;
    win_lo     = 0;
    win_hi     = 0;
    inner_lo   = 0;
    inner_hi   = 0;
    reuse_val  = 0;
    move_lo    = 1'b0;
    last_point = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: widest stop width first, so the full-range search ends in a few compares.
    configure_stop({gsm_pkg::STOP_W{1'b1}});
    // value while idle
    issue(gsm_pkg::REQ_VALUE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    // full signed range
    issue(gsm_pkg::REQ_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // start while busy
    issue(gsm_pkg::REQ_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    run_search(32'h8000_0000, 32'h7FFF_FFFF, SH_BOWL, 32'h1234_5678, 1'b0);
    // Reversed bounds: the first compare leaves a width at or below zero.
    run_search(32'h7FFF_FFFF, 32'h8000_0000, SH_FLAT, 32'h7FFF_FFFF, 1'b0);
    run_search(32'h0, 32'h0, SH_FLAT, 32'h8000_0000, 1'b0);
    // Narrowest stop width; constant values make every compare a tie.
    configure_stop(1);
    run_search(-32'sd5, 32'sd5, SH_FLAT, 32'h0, 1'b0);
    run_search(32'sd100, 32'sd101, SH_BOWL, 32'sd100, 1'b0);

    // Random phases, each under a fresh stop width including both extremes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0:       next_stop = 1;
        1:       next_stop = $urandom_range(1, 1 << 16);
        2:       next_stop = {gsm_pkg::STOP_W{1'b1}};
        default: next_stop = $urandom_range(1, 32'h7FFF_FFFF);
      endcase
      configure_stop(next_stop);
      goal = useful_items + PHASE_ITEMS;
      while (useful_items < goal) begin
        roll = $urandom_range(0, 9);
        lo   = $urandom;
        if (roll < 6) hi = lo + $urandom_range(0, 1 << 20);
        else if (roll < 8) hi = $urandom;
        else if (roll < 9) hi = lo + $urandom_range(0, 3);
        else hi = lo;
        aim = $urandom_range(0, 1) ? $urandom : lo + $urandom_range(0, 1 << 20);
        run_search(lo, hi, shape_e'($urandom_range(0, 4)), aim, 1'b1);
      end
    end

    // Drain, then leave room for the registered result path before judging.
    while (requests_todo.size() != 0 || answers_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
src/gsm_pkg.sv
src/gsm_golden_step.sv
src/golden_section_minimizer.sv
src/gsm_checker.sv
tb/sv/golden_section_minimizer_tb.sv
